FILE: rtl/core/hatt_pkg.sv
// ----------------------------------------------------------------------------
// hatt_pkg
// Shared types, constants and the arctangent table for the heading and
// travel time pipeline.
// ----------------------------------------------------------------------------
package hatt_pkg;

	// cordic angle accumulator, degrees with 16 fraction bits
	localparam int CORDIC_STEPS = 16;
	localparam int ANG_W        = 24;
	localparam int ANG_FRAC     = 16;

	// configuration port
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_W-1:0] TPS_RST = 16'd1000;
	localparam logic [CFG_W-1:0] PPS_RST = 16'd300;
	localparam logic [CFG_W-1:0] FTT_RST = 16'd2000;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TPS = 2'd0,
		CFG_PPS = 2'd1,
		CFG_FTT = 2'd2
	} cfg_idx_t;

	// result field widths
	localparam int DIST_W = 11;
	localparam int HEAD_W = 9;
	localparam int TICK_W = 16;
	localparam int DRV_W  = 15;
	localparam int MAG_W  = 8;

	// heading constants in whole degrees
	localparam logic [HEAD_W-1:0] DEG_90  = 9'd90;
	localparam logic [HEAD_W-1:0] DEG_180 = 9'd180;
	localparam logic [HEAD_W-1:0] DEG_270 = 9'd270;
	localparam logic [HEAD_W-1:0] DEG_360 = 9'd360;

	// extra rotation ticks on a straight
	localparam logic [TICK_W-1:0] STRAIGHT_EXTRA = 16'd40;

	// exact reciprocals: ceil(2^sh / d), valid for the operand ranges used
	localparam logic [24:0] RECIP_360    = 25'd23860930;
	localparam int          RECIP_360_SH = 33;
	localparam logic [19:0] RECIP_10     = 20'd838861;
	localparam int          RECIP_10_SH  = 23;

	typedef logic signed [ANG_W-1:0] ang_t;

	// quadrant flags and pass-through fields riding beside the cordic
	typedef struct packed {
		logic              dx_neg;
		logic              dx_zero;
		logic              dy_neg;
		logic              dy_zero;
		logic [HEAD_W-1:0] ph;
		logic              st;
	} side_t;

	// heading results waiting for the drive path
	typedef struct packed {
		logic [HEAD_W-1:0] heading;
		logic              ccw;
		logic [TICK_W-1:0] ticks;
	} head_t;

	// atan(2^-i) in degrees, 16 fraction bits
	function automatic ang_t atan_q16(input int idx);
		ang_t v;
		unique case (idx)
			0:  v = 24'sd2949120;
			1:  v = 24'sd1740967;
			2:  v = 24'sd919879;
			3:  v = 24'sd466945;
			4:  v = 24'sd234379;
			5:  v = 24'sd117304;
			6:  v = 24'sd58666;
			7:  v = 24'sd29335;
			8:  v = 24'sd14668;
			9:  v = 24'sd7334;
			10: v = 24'sd3667;
			11: v = 24'sd1833;
			12: v = 24'sd917;
			13: v = 24'sd458;
			14: v = 24'sd229;
			15: v = 24'sd115;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

FILE: rtl/core/hatt_if.sv
// ----------------------------------------------------------------------------
// hatt_if
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface hatt_cmd_if #(parameter int COORD_BITS = 10);
	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] target_x;
	logic [COORD_BITS-1:0] target_y;
	logic [COORD_BITS-1:0] pos_x;
	logic [COORD_BITS-1:0] pos_y;
	logic [8:0]            pos_heading;
	logic                  straight_section;

	modport source (output valid, target_x, target_y, pos_x, pos_y, pos_heading,
		straight_section, input ready);
	modport sink (input valid, target_x, target_y, pos_x, pos_y, pos_heading,
		straight_section, output ready);
endinterface

interface hatt_res_if;
	logic        valid;
	logic        ready;
	logic [10:0] distance;
	logic [8:0]  wanted_heading;
	logic        turn_ccw;
	logic [15:0] turn_ticks;
	logic [14:0] drive_ticks;

	modport source (output valid, distance, wanted_heading, turn_ccw, turn_ticks,
		drive_ticks, input ready);
	modport sink (input valid, distance, wanted_heading, turn_ccw, turn_ticks,
		drive_ticks, output ready);
endinterface

FILE: rtl/core/hatt_delay.sv
// ----------------------------------------------------------------------------
// hatt_delay
// Enabled delay line that keeps side data level with a longer path.
// ----------------------------------------------------------------------------
module hatt_delay #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             en,
	input  logic [WIDTH-1:0] d,
	output logic [WIDTH-1:0] q
);

	logic [WIDTH-1:0] dl_s [DEPTH];

	// shift one place per advancing cycle
	always_ff @(posedge clk) begin
		if (en) begin
			dl_s[0] <= d;
			for (int k = 1; k < DEPTH; k++) begin
				dl_s[k] <= dl_s[k-1];
			end
		end
	end

	assign q = dl_s[DEPTH-1];

endmodule

FILE: rtl/core/hatt_cordic.sv
// ----------------------------------------------------------------------------
// hatt_cordic
// Vectoring cordic, one micro-rotation per stage, angle in degrees.
// ----------------------------------------------------------------------------
module hatt_cordic #(
	parameter int COORD_BITS = 10,
	parameter int FRAC_BITS  = 8
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [COORD_BITS-1:0] ax,
	input  logic [COORD_BITS-1:0] ay,
	output hatt_pkg::ang_t        ang
);

	localparam int XW = COORD_BITS + FRAC_BITS + 3;
	localparam int N  = hatt_pkg::CORDIC_STEPS;

	logic signed [XW-1:0] x_s [N-1];
	logic signed [XW-1:0] y_s [N-1];
	hatt_pkg::ang_t       z_s [N];

	for (genvar i = 0; i < N; i++) begin : g_step
		logic signed [XW-1:0] x_in, y_in, xs, ys;
		hatt_pkg::ang_t       z_in;

		if (i == 0) begin : g_first
			assign x_in = $signed({3'b000, ax, {FRAC_BITS{1'b0}}});
			assign y_in = $signed({3'b000, ay, {FRAC_BITS{1'b0}}});
			assign z_in = '0;
		end else begin : g_next
			assign x_in = x_s[i-1];
			assign y_in = y_s[i-1];
			assign z_in = z_s[i-1];
		end

		// floor shifts of the current vector
		assign xs = x_in >>> i;
		assign ys = y_in >>> i;

		// angle accumulation, direction from the sign of y
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_in > 0) begin
					z_s[i] <= z_in + hatt_pkg::atan_q16(i);
				end else begin
					z_s[i] <= z_in - hatt_pkg::atan_q16(i);
				end
			end
		end

		// vector rotation, not needed after the last step
		if (i < N - 1) begin : g_rot
			always_ff @(posedge clk) begin
				if (en) begin
					if (y_in > 0) begin
						x_s[i] <= x_in + ys;
						y_s[i] <= y_in - xs;
					end else begin
						x_s[i] <= x_in - ys;
						y_s[i] <= y_in + xs;
					end
				end
			end
		end
	end

	assign ang = z_s[N-1];

endmodule

FILE: rtl/core/hatt_isqrt.sv
// ----------------------------------------------------------------------------
// hatt_isqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module hatt_isqrt #(
	parameter int IN_W = 21
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [IN_W-1:0]       rad,
	output logic [(IN_W+1)/2-1:0] root
);

	localparam int RT_W = (IN_W + 1) / 2;
	localparam int SQ_W = 2 * RT_W;

	logic [IN_W-1:0] rad_s [RT_W-1];
	logic [SQ_W-1:0] sq_s  [RT_W-1];
	logic [RT_W-1:0] rt_s  [RT_W];

	for (genvar k = 0; k < RT_W; k++) begin : g_bit
		localparam int B = RT_W - 1 - k;
		logic [IN_W-1:0] rad_in;
		logic [SQ_W-1:0] sq_in, cand_sq;
		logic [RT_W-1:0] rt_in;
		logic            take;

		if (k == 0) begin : g_first
			assign rad_in = rad;
			assign sq_in  = '0;
			assign rt_in  = '0;
		end else begin : g_next
			assign rad_in = rad_s[k-1];
			assign sq_in  = sq_s[k-1];
			assign rt_in  = rt_s[k-1];
		end

		// square of the candidate root, built up from the previous square
		assign cand_sq = sq_in + (SQ_W'(rt_in) << (B + 1)) + (SQ_W'(1) << (2 * B));
		assign take    = cand_sq <= SQ_W'(rad_in);

		always_ff @(posedge clk) begin
			if (en) begin
				rt_s[k] <= take ? (rt_in | (RT_W'(1) << B)) : rt_in;
			end
		end

		if (k < RT_W - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					rad_s[k] <= rad_in;
					sq_s[k]  <= take ? cand_sq : sq_in;
				end
			end
		end
	end

	assign root = rt_s[RT_W-1];

endmodule

FILE: rtl/core/hatt_drive.sv
// ----------------------------------------------------------------------------
// hatt_drive
// Bit-per-stage search for the largest drive count n with n <= limit and
// (n * pps)^2 <= 9 * tps^2 * d^2.
// ----------------------------------------------------------------------------
module hatt_drive #(
	parameter int A_W = 57
) (
	input  logic                                clk,
	input  logic                                en,
	input  logic [A_W-1:0]                      a,
	input  logic [2*hatt_pkg::CFG_W-1:0]        pps_sq,
	input  logic [hatt_pkg::DRV_W-1:0]          limit,
	output logic [hatt_pkg::DRV_W-1:0]          n
);

	localparam int NW  = hatt_pkg::DRV_W;
	localparam int Q_W = 2 * hatt_pkg::CFG_W;
	localparam int T_W = NW + Q_W;
	localparam int S_W = 2 * (NW + hatt_pkg::CFG_W);
	localparam int C_W = (A_W > S_W) ? A_W : S_W;

	logic [A_W-1:0] a_s [NW-1];
	logic [T_W-1:0] t_s [NW-1];
	logic [S_W-1:0] s_s [NW-1];
	logic [NW-1:0]  n_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_bit
		localparam int B = NW - 1 - k;
		logic [A_W-1:0] a_in;
		logic [T_W-1:0] t_in, t_new;
		logic [S_W-1:0] s_in, s_new;
		logic [NW-1:0]  n_in, cand;
		logic           take;

		if (k == 0) begin : g_first
			assign a_in = a;
			assign t_in = '0;
			assign s_in = '0;
			assign n_in = '0;
		end else begin : g_next
			assign a_in = a_s[k-1];
			assign t_in = t_s[k-1];
			assign s_in = s_s[k-1];
			assign n_in = n_s[k-1];
		end

		// t tracks n * pps^2, s tracks (n * pps)^2
		assign cand  = n_in | (NW'(1) << B);
		assign t_new = t_in + (T_W'(pps_sq) << B);
		assign s_new = s_in + (S_W'(t_in) << (B + 1)) + (S_W'(pps_sq) << (2 * B));
		assign take  = (cand <= limit) && (C_W'(s_new) <= C_W'(a_in));

		always_ff @(posedge clk) begin
			if (en) begin
				n_s[k] <= take ? cand : n_in;
			end
		end

		if (k < NW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en) begin
					a_s[k] <= a_in;
					t_s[k] <= take ? t_new : t_in;
					s_s[k] <= take ? s_new : s_in;
				end
			end
		end
	end

	assign n = n_s[NW-1];

endmodule

FILE: rtl/core/heading_and_travel_time.sv
// ----------------------------------------------------------------------------
// heading_and_travel_time
// Distance, wanted heading, turn and drive timer lengths toward a target.
// ----------------------------------------------------------------------------
// One command word enters per clock and its result word leaves the last
// stage; the depth is set by the drive-time path (input, squaring and
// scaling stages, a 15-stage bit search and a two-stage scale by 9/10),
// with the 16-stage cordic and the distance square root padded to match.
// When the result side stalls the whole pipeline holds in place, so the
// command side stays ready whenever the output register is empty or being
// taken. Configuration writes take effect for words accepted afterwards.
// ----------------------------------------------------------------------------
module heading_and_travel_time #(
	parameter int FRAC_BITS  = 8,
	parameter int COORD_BITS = 10
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [hatt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [hatt_pkg::CFG_W-1:0]     cfg_data,
	hatt_cmd_if.sink                       cmd,
	hatt_res_if.source                     res
);

	localparam int LAT      = 23;
	localparam int D_W      = COORD_BITS + 1;
	localparam int SQ_W     = 2 * COORD_BITS;
	localparam int D2_W     = 2 * COORD_BITS + 1;
	localparam int RT_W     = (D2_W + 1) / 2;
	localparam int P_W      = hatt_pkg::CFG_W + D2_W;
	localparam int A1_W     = 2 * hatt_pkg::CFG_W + D2_W;
	localparam int A_W      = A1_W + 4;
	localparam int DIST_DLY = LAT - 3 - RT_W;
	localparam int V_W      = hatt_pkg::DRV_W + 4;
	localparam int W10_W    = V_W + 20;
	localparam int PT_W     = hatt_pkg::CFG_W + hatt_pkg::MAG_W;
	localparam int W360_W   = PT_W + 25;
	localparam int CW       = hatt_pkg::CFG_W;

	// configuration registers
	logic [CW-1:0]   tps_q, pps_q, ftt_q;
	logic [2*CW-1:0] tsq_q, psq_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q <= hatt_pkg::TPS_RST;
			pps_q <= hatt_pkg::PPS_RST;
			ftt_q <= hatt_pkg::FTT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				hatt_pkg::CFG_TPS: tps_q <= cfg_data;
				hatt_pkg::CFG_PPS: pps_q <= cfg_data;
				hatt_pkg::CFG_FTT: ftt_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// squares of the rate registers, settled long before a word needs them
	always_ff @(posedge clk) begin
		tsq_q <= (2*CW)'(tps_q) * (2*CW)'(tps_q);
		psq_q <= (2*CW)'(pps_q) * (2*CW)'(pps_q);
	end

	// pipeline advance and valid bits
	logic           en, accept;
	logic [LAT:1]   vld_q;

	assign en        = !vld_q[LAT] || res.ready;
	assign accept    = cmd.valid && en;
	assign cmd.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-1:1], accept};
		end
	end

	// stage 1: offsets and quadrant flags
	logic signed [D_W-1:0] dx_c, dy_c, dx_s1, dy_s1;
	hatt_pkg::side_t       side_c, side_s1, side17;

	assign dx_c = $signed({1'b0, cmd.target_x}) - $signed({1'b0, cmd.pos_x});
	assign dy_c = $signed({1'b0, cmd.target_y}) - $signed({1'b0, cmd.pos_y});

	always_comb begin
		side_c.dx_neg  = dx_c[D_W-1];
		side_c.dx_zero = dx_c == '0;
		side_c.dy_neg  = dy_c[D_W-1];
		side_c.dy_zero = dy_c == '0;
		side_c.ph      = cmd.pos_heading;
		side_c.st      = cmd.straight_section;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= dx_c;
			dy_s1   <= dy_c;
			side_s1 <= side_c;
		end
	end

	logic [COORD_BITS-1:0] ax_c, ay_c;

	assign ax_c = COORD_BITS'(dx_s1[D_W-1] ? -dx_s1 : dx_s1);
	assign ay_c = COORD_BITS'(dy_s1[D_W-1] ? -dy_s1 : dy_s1);

	// stages 2 and 3: squared distance
	logic [SQ_W-1:0] axx_s2, ayy_s2;
	logic [D2_W-1:0] d2_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			axx_s2 <= SQ_W'(ax_c) * SQ_W'(ax_c);
			ayy_s2 <= SQ_W'(ay_c) * SQ_W'(ay_c);
			d2_s3  <= D2_W'(axx_s2) + D2_W'(ayy_s2);
		end
	end

	// distance: square root, then padded to the output stage
	logic [RT_W-1:0] root_c, dist_out;

	hatt_isqrt #(.IN_W(D2_W)) u_dist (
		.clk  (clk),
		.en   (en),
		.rad  (d2_s3),
		.root (root_c)
	);

	hatt_delay #(.WIDTH(RT_W), .DEPTH(DIST_DLY)) u_dist_dly (
		.clk (clk),
		.en  (en),
		.d   (root_c),
		.q   (dist_out)
	);

	// stages 4 to 6: a = 9 * tps^2 * d^2 from split products
	logic [P_W-1:0]  alo_s4, ahi_s4;
	logic [A1_W-1:0] a1_s5;
	logic [A_W-1:0]  a_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			alo_s4 <= P_W'(tsq_q[CW-1:0]) * P_W'(d2_s3);
			ahi_s4 <= P_W'(tsq_q[2*CW-1:CW]) * P_W'(d2_s3);
			a1_s5  <= (A1_W'(ahi_s4) << CW) + A1_W'(alo_s4);
			a_s6   <= A_W'(a1_s5) + (A_W'(a1_s5) << 3);
		end
	end

	// stages 7 to 21: drive count search, clamped to half a second
	logic [hatt_pkg::DRV_W-1:0] drv_n;

	hatt_drive #(.A_W(A_W)) u_drive (
		.clk    (clk),
		.en     (en),
		.a      (a_s6),
		.pps_sq (psq_q),
		.limit  (tps_q[CW-1:1]),
		.n      (drv_n)
	);

	// stages 22 and 23: scale by nine tenths
	logic [V_W-1:0]             v_s22;
	logic [hatt_pkg::DRV_W-1:0] drv_s23;

	always_ff @(posedge clk) begin
		if (en) begin
			v_s22   <= V_W'(drv_n) + (V_W'(drv_n) << 3);
			drv_s23 <= hatt_pkg::DRV_W'((W10_W'(v_s22) * W10_W'(hatt_pkg::RECIP_10))
				>> hatt_pkg::RECIP_10_SH);
		end
	end

	// stages 2 to 17: heading angle
	hatt_pkg::ang_t ang17;

	hatt_cordic #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_cordic (
		.clk (clk),
		.en  (en),
		.ax  (ax_c),
		.ay  (ay_c),
		.ang (ang17)
	);

	hatt_delay #(.WIDTH($bits(hatt_pkg::side_t)), .DEPTH(hatt_pkg::CORDIC_STEPS)) u_side_dly (
		.clk (clk),
		.en  (en),
		.d   (side_s1),
		.q   (side17)
	);

	// stage 18: whole degrees, quadrant fold and turn wrap
	logic [6:0]                  zi_c, deg_c;
	logic [hatt_pkg::HEAD_W-1:0] deg9_c, h_c;
	logic signed [10:0]          t0_c, t1_c, t2_c;

	assign zi_c   = ang17[hatt_pkg::ANG_FRAC+6:hatt_pkg::ANG_FRAC];
	assign deg_c  = ang17[hatt_pkg::ANG_W-1] ? 7'd0 : ((zi_c > 7'd90) ? 7'd90 : zi_c);
	assign deg9_c = hatt_pkg::HEAD_W'(deg_c);

	always_comb begin
		priority if (side17.dx_zero) begin
			if (side17.dy_zero) h_c = '0;
			else if (side17.dy_neg) h_c = hatt_pkg::DEG_270;
			else h_c = hatt_pkg::DEG_90;
		end else if (side17.dx_neg) begin
			if (side17.dy_neg) h_c = (deg9_c == '0) ? '0 : hatt_pkg::DEG_360 - deg9_c;
			else if (side17.dy_zero) h_c = '0;
			else h_c = deg9_c;
		end else begin
			if (side17.dy_neg) h_c = hatt_pkg::DEG_180 + deg9_c;
			else if (side17.dy_zero) h_c = hatt_pkg::DEG_180;
			else h_c = hatt_pkg::DEG_180 - deg9_c;
		end
	end

	assign t0_c = $signed({2'b00, h_c}) - $signed({2'b00, side17.ph});
	assign t1_c = (t0_c > 11'sd180) ? t0_c - 11'sd360 : t0_c;
	assign t2_c = (t1_c < -11'sd180) ? t1_c + 11'sd360 : t1_c;

	logic [hatt_pkg::HEAD_W-1:0] h_s18, h_s19, h_s20;
	logic [hatt_pkg::MAG_W-1:0]  mag_s18;
	logic                        ccw_s18, zero_s18, st_s18;
	logic                        ccw_s19, zero_s19, st_s19;
	logic                        ccw_s20, zero_s20, st_s20;
	logic [PT_W-1:0]             p_s19;
	logic [hatt_pkg::TICK_W-1:0] q_s20;
	hatt_pkg::head_t             head_s21, head23;

	// stages 18 to 21: rotation ticks = ftt * |turn| / 360, one tick for no turn, plus the straight extra
	always_ff @(posedge clk) begin
		if (en) begin
			h_s18    <= h_c;
			mag_s18  <= hatt_pkg::MAG_W'(t2_c[10] ? -t2_c : t2_c);
			ccw_s18  <= t2_c > 11'sd0;
			zero_s18 <= t2_c == 11'sd0;
			st_s18   <= side17.st;

			p_s19    <= PT_W'(ftt_q) * PT_W'(mag_s18);
			h_s19    <= h_s18;
			ccw_s19  <= ccw_s18;
			zero_s19 <= zero_s18;
			st_s19   <= st_s18;

			q_s20    <= hatt_pkg::TICK_W'((W360_W'(p_s19) * W360_W'(hatt_pkg::RECIP_360))
				>> hatt_pkg::RECIP_360_SH);
			h_s20    <= h_s19;
			ccw_s20  <= ccw_s19;
			zero_s20 <= zero_s19;
			st_s20   <= st_s19;

			head_s21.heading <= h_s20;
			head_s21.ccw     <= ccw_s20;
			head_s21.ticks   <= (zero_s20 ? hatt_pkg::TICK_W'(1) : q_s20)
				+ (st_s20 ? hatt_pkg::STRAIGHT_EXTRA : '0);
		end
	end

	hatt_delay #(.WIDTH($bits(hatt_pkg::head_t)), .DEPTH(LAT - 21)) u_head_dly (
		.clk (clk),
		.en  (en),
		.d   (head_s21),
		.q   (head23)
	);

	// result word
	assign res.valid          = vld_q[LAT];
	assign res.distance       = hatt_pkg::DIST_W'(dist_out);
	assign res.wanted_heading = head23.heading;
	assign res.turn_ccw       = head23.ccw;
	assign res.turn_ticks     = head23.ticks;
	assign res.drive_ticks    = drv_s23;

	// heading always folded into a full circle
	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> res.wanted_heading < hatt_pkg::DEG_360)
		else $error("wanted heading outside 0..359");

	// drive ticks never exceed nine tenths of half a second
	a_drive_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> ({5'd0, res.drive_ticks} * 20'd10) <= ({5'd0, tps_q[CW-1:1]} * 20'd9))
		else $error("drive ticks above clamp");

	// a stalled result word holds still until taken
	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.ready |=> res.valid && $stable(res.distance)
			&& $stable(res.wanted_heading) && $stable(res.turn_ccw)
			&& $stable(res.turn_ticks) && $stable(res.drive_ticks))
		else $error("stalled result word changed");

endmodule
